@@ rtl/core/codepage_text_transcoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the code page text transcoder
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CODEPAGE_TEXT_TRANSCODER_ASSERT_SVH
`define CODEPAGE_TEXT_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define CTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Check that a condition never holds
`define CTT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define CTT_ASSERT(lbl, prop, msg)
`define CTT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/ctt_pkg.sv @@
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, code page constants and character mapping functions.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_PAGE = 2'd1;

  // Input pages
  localparam logic [1:0] IN_RAW    = 2'd0;
  localparam logic [1:0] IN_CP1251 = 2'd1;
  localparam logic [1:0] IN_UTF8   = 2'd2;
  localparam logic [1:0] IN_U16LE  = 2'd3;

  // Output pages
  localparam logic [2:0] OUT_RAW    = 3'd0;
  localparam logic [2:0] OUT_CP1251 = 3'd1;
  localparam logic [2:0] OUT_UTF8   = 3'd2;
  localparam logic [2:0] OUT_U16LE  = 3'd3;
  localparam logic [2:0] OUT_U16BE  = 3'd4;

  // CP1251 Cyrillic block and Ukrainian letters
  localparam logic [7:0]  CP_CYR_LOW = 8'hC0;
  localparam logic [15:0] UC_CYR_LOW = 16'h0410;
  localparam logic [15:0] UC_CYR_HI  = 16'h044F;
  localparam logic [7:0]  CP_I_UP    = 8'hB2;
  localparam logic [7:0]  CP_YI_UP   = 8'hAF;
  localparam logic [7:0]  CP_I_LO    = 8'hB3;
  localparam logic [7:0]  CP_YI_LO   = 8'hBF;
  localparam logic [15:0] UC_I_UP    = 16'h0406;
  localparam logic [15:0] UC_YI_UP   = 16'h0407;
  localparam logic [15:0] UC_I_LO    = 16'h0456;
  localparam logic [15:0] UC_YI_LO   = 16'h0457;

  // UTF-8 lead byte ranges and continuation offset
  localparam logic [7:0]  U8_LEAD2_LO = 8'd192;
  localparam logic [7:0]  U8_LEAD2_HI = 8'd223;
  localparam logic [7:0]  U8_LEAD3_LO = 8'd224;
  localparam logic [7:0]  U8_LEAD3_HI = 8'd239;
  localparam logic [15:0] U8_CONT     = 16'd128;
  localparam logic [15:0] U8_ONE_LIM  = 16'd128;
  localparam logic [15:0] U8_TWO_LIM  = 16'd2048;

  // Configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  // One decoded code point
  typedef struct packed {
    logic        valid;
    logic [15:0] point;
  } cp_word_t;

  function automatic logic [15:0] from_cp1251(logic [7:0] b);
    logic [15:0] r;
    if (b >= CP_CYR_LOW) begin
      r = UC_CYR_LOW + {8'h00, b} - {8'h00, CP_CYR_LOW};
    end else begin
      case (b)
        CP_I_UP:  r = UC_I_UP;
        CP_YI_UP: r = UC_YI_UP;
        CP_I_LO:  r = UC_I_LO;
        CP_YI_LO: r = UC_YI_LO;
        default:  r = {8'h00, b};
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] to_cp1251(logic [15:0] cp);
    logic [15:0] t;
    logic [7:0]  r;
    t = cp - UC_CYR_LOW + {8'h00, CP_CYR_LOW};
    if (cp >= UC_CYR_LOW && cp <= UC_CYR_HI) begin
      r = t[7:0];
    end else begin
      case (cp)
        UC_I_UP:  r = CP_I_UP;
        UC_YI_UP: r = CP_YI_UP;
        UC_I_LO:  r = CP_I_LO;
        UC_YI_LO: r = CP_YI_LO;
        default:  r = cp[7:0];
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ctt_decode.sv @@
// ----------------------------------------------------------------------------
// ctt_decode
// Front end: accepts input words, gathers multi-byte characters and
// pushes each finished code point into the queue.
// ----------------------------------------------------------------------------
module ctt_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctt_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output ctt_pkg::cp_word_t push_o
);
  import ctt_pkg::*;

  logic [1:0]  in_page_q;
  logic [15:0] part_q, part_d;
  logic [1:0]  pend_q, pend_d;
  logic        accept;
  logic        cfg_in_wr;
  logic [15:0] b16;
  logic [15:0] cont;
  logic [15:0] point;
  logic        emit;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cfg_in_wr  = cfg_i.we && (cfg_i.idx == REG_IN_PAGE);
  assign b16        = {8'h00, in_byte_i};
  assign cont       = b16 - U8_CONT;

  // Classify the word and advance the partial character
  always_comb begin
    part_d = part_q;
    pend_d = pend_q;
    point  = b16;
    emit   = 1'b0;
    if (pend_q != 2'd0) begin
      if (in_page_q == IN_U16LE) begin
        point  = part_q | {in_byte_i, 8'h00};
        emit   = 1'b1;
        part_d = '0;
        pend_d = 2'd0;
      end else if (pend_q == 2'd2) begin
        part_d = part_q + {cont[9:0], 6'b0};
        pend_d = 2'd1;
      end else begin
        point  = part_q + cont;
        emit   = 1'b1;
        part_d = '0;
        pend_d = 2'd0;
      end
    end else begin
      case (in_page_q)
        IN_CP1251: begin
          point = from_cp1251(in_byte_i);
          emit  = 1'b1;
        end
        IN_UTF8: begin
          if (in_byte_i >= U8_LEAD2_LO && in_byte_i <= U8_LEAD2_HI) begin
            part_d = {5'b0, in_byte_i[4:0], 6'b0};
            pend_d = 2'd1;
          end else if (in_byte_i >= U8_LEAD3_LO && in_byte_i <= U8_LEAD3_HI) begin
            part_d = {in_byte_i[3:0], 12'b0};
            pend_d = 2'd2;
          end else begin
            emit = 1'b1;
          end
        end
        IN_U16LE: begin
          part_d = b16;
          pend_d = 2'd1;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
  end

  assign push_o.valid = accept && emit;
  assign push_o.point = point;

  // Hold page and partial character; a page write drops any partial one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_page_q <= IN_RAW;
      part_q    <= '0;
      pend_q    <= 2'd0;
    end else if (cfg_in_wr) begin
      in_page_q <= cfg_i.data[1:0];
      part_q    <= '0;
      pend_q    <= 2'd0;
    end else if (accept) begin
      part_q    <= part_d;
      pend_q    <= pend_d;
    end
  end

endmodule

@@ rtl/core/ctt_queue.sv @@
// ----------------------------------------------------------------------------
// ctt_queue
// Two-entry code point queue between the decoder and the encoder.
// ----------------------------------------------------------------------------
`include "codepage_text_transcoder_assert.svh"

module ctt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctt_pkg::cp_word_t push_i,
  output logic              full_o,
  output ctt_pkg::cp_word_t head_o,
  input  logic              pop_i
);
  import ctt_pkg::*;

  logic [1:0][15:0] mem_q;
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.point = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.point;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i.valid) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)        rd_ptr_q <= ~rd_ptr_q;
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i.valid) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  `CTT_ASSERT_NEVER(a_push_full, push_i.valid && full_o, "push into full queue")
  `CTT_ASSERT_NEVER(a_pop_empty, pop_i && !head_o.valid, "pop from empty queue")
  `CTT_ASSERT(a_ptr_cnt, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "pointers and count disagree")

endmodule

@@ rtl/core/ctt_encode.sv @@
// ----------------------------------------------------------------------------
// ctt_encode
// Back end: takes a code point from the queue, encodes it in the output
// page and sends its one to three bytes, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "codepage_text_transcoder_assert.svh"

module ctt_encode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctt_pkg::cfg_t     cfg_i,
  input  ctt_pkg::cp_word_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              char_done_o
);
  import ctt_pkg::*;

  logic [2:0]      out_page_q;
  logic            busy_q;
  logic [1:0]      idx_q;
  logic [1:0]      last_q;
  logic [2:0][7:0] bytes_q;
  logic [2:0][7:0] enc_bytes;
  logic [1:0]      enc_last;
  logic            take;
  logic            at_last;
  logic            load;
  logic [15:0]     cp;

  assign cp = head_i.point;

  // Encode the head code point
  always_comb begin
    enc_bytes = '0;
    enc_last  = 2'd0;
    case (out_page_q)
      OUT_CP1251: begin
        enc_bytes[0] = to_cp1251(cp);
      end
      OUT_UTF8: begin
        if (cp < U8_ONE_LIM) begin
          enc_bytes[0] = cp[7:0];
        end else if (cp < U8_TWO_LIM) begin
          enc_bytes[0] = {3'b110, cp[10:6]};
          enc_bytes[1] = {2'b10, cp[5:0]};
          enc_last     = 2'd1;
        end else begin
          enc_bytes[0] = {4'b1110, cp[15:12]};
          enc_bytes[1] = {2'b10, cp[11:6]};
          enc_bytes[2] = {2'b10, cp[5:0]};
          enc_last     = 2'd2;
        end
      end
      OUT_U16LE: begin
        enc_bytes[0] = cp[7:0];
        enc_bytes[1] = cp[15:8];
        enc_last     = 2'd1;
      end
      OUT_U16BE: begin
        enc_bytes[0] = cp[15:8];
        enc_bytes[1] = cp[7:0];
        enc_last     = 2'd1;
      end
      default: begin
        enc_bytes[0] = cp[7:0];
      end
    endcase
  end

  assign take    = busy_q && !out_stall_i;
  assign at_last = (idx_q == last_q);
  assign load    = head_i.valid && (!busy_q || (take && at_last));
  assign pop_o   = load;

  assign out_valid_o = busy_q;
  assign out_byte_o  = bytes_q[idx_q];
  assign char_done_o = at_last;

  // Hold encoded bytes of the current character
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= enc_bytes;
      last_q  <= enc_last;
    end
  end

  // Step through the bytes and refill from the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q  <= idx_q + 2'd1;
      end
    end
  end

  // Output page register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_page_q <= OUT_RAW;
    end else if (cfg_i.we && (cfg_i.idx == REG_OUT_PAGE)) begin
      out_page_q <= cfg_i.data;
    end
  end

  `CTT_ASSERT(a_idx_range, busy_q |-> (idx_q <= last_q), "byte index past last byte")
  `CTT_ASSERT(a_mid_char, (take && !at_last) |=> (busy_q && idx_q == $past(idx_q) + 2'd1), "character cut short")
  `CTT_ASSERT(a_load_first, load |=> (busy_q && idx_q == 2'd0), "new character not started at first byte")

endmodule

@@ rtl/core/codepage_text_transcoder.sv @@
// ----------------------------------------------------------------------------
// codepage_text_transcoder
// Re-encodes a byte stream from one text code page into another.
// ----------------------------------------------------------------------------
// The block takes one input word (text byte) per cycle while its two-entry
// code point queue has room, and sends one output word per cycle while the
// output is not stalled. Input pages are raw, CP1251, UTF-8 (up to three
// bytes) and UTF-16LE; output pages are raw, CP1251, UTF-8, UTF-16LE and
// UTF-16BE. The encoder holds one character in its output byte register and
// sends its one to three output bytes in turn, so multi-byte output fills
// the queue and holds back input. The first output word of a character
// passes the queue and the encoder's byte register after its last input
// word is accepted. Write in_page only while idle; doing so drops a partly
// received character. Writes to unused indexes are ignored.
module codepage_text_transcoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           char_done_o
);
  import ctt_pkg::*;

  cfg_t     cfg;
  cp_word_t push;
  cp_word_t head;
  logic     q_full;
  logic     pop;

  // Bundle the configuration write
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  ctt_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  ctt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ctt_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .char_done_o (char_done_o)
  );

endmodule

@@ sim/codepage_text_transcoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code page transcoder scoreboard
// Watches the register port and both word channels. Predicts the output
// words of every accepted input byte and compares each output word, in
// order, with the oldest word still due.
// ----------------------------------------------------------------------------
module codepage_text_transcoder_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     in_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     out_byte_i,
  input  logic                           char_done_i,
  output int unsigned                    err_cnt_o,
  output int unsigned                    words_due_o
);
  import ctt_pkg::*;

  localparam int unsigned PRINT_CAP = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t   due_q[$];
  out_word_t   want;
  logic [1:0]  in_pg     = IN_RAW;
  logic [2:0]  out_pg    = OUT_RAW;
  logic [15:0] acc_point = '0;
  logic [1:0]  owed      = '0;
  int unsigned errs      = 0;

  // Map a CP1251 byte to its code point
  function automatic logic [15:0] point_of_cp1251(logic [7:0] b);
    logic [15:0] r;
    if (b >= CP_CYR_LOW) begin
      r = {8'h04, b - 8'hB0};
    end else begin
      case (b)
        CP_I_UP:  r = UC_I_UP;
        CP_YI_UP: r = UC_YI_UP;
        CP_I_LO:  r = UC_I_LO;
        CP_YI_LO: r = UC_YI_LO;
        default:  r = {8'h00, b};
      endcase
    end
    return r;
  endfunction

  // Map a code point to CP1251; unmapped points keep their low byte
  function automatic logic [7:0] cp1251_of_point(logic [15:0] cp);
    logic [7:0] r;
    if (cp >= UC_CYR_LOW && cp <= UC_CYR_HI) begin
      r = cp[7:0] + 8'hB0;
    end else begin
      case (cp)
        UC_I_UP:  r = CP_I_UP;
        UC_YI_UP: r = CP_YI_UP;
        UC_I_LO:  r = CP_I_LO;
        UC_YI_LO: r = CP_YI_LO;
        default:  r = cp[7:0];
      endcase
    end
    return r;
  endfunction

  task automatic push_word(input logic [7:0] data, input logic last);
    out_word_t w;
    w.data = data;
    w.last = last;
    due_q.push_back(w);
  endtask

  // Queue the output words of one finished code point
  task automatic encode_point(input logic [15:0] cp);
    case (out_pg)
      OUT_CP1251: push_word(cp1251_of_point(cp), 1'b1);
      OUT_UTF8: begin
        if (cp < U8_ONE_LIM) begin
          push_word(cp[7:0], 1'b1);
        end else if (cp < U8_TWO_LIM) begin
          push_word({3'b110, cp[10:6]}, 1'b0);
          push_word({2'b10, cp[5:0]}, 1'b1);
        end else begin
          push_word({4'b1110, cp[15:12]}, 1'b0);
          push_word({2'b10, cp[11:6]}, 1'b0);
          push_word({2'b10, cp[5:0]}, 1'b1);
        end
      end
      OUT_U16LE: begin
        push_word(cp[7:0], 1'b0);
        push_word(cp[15:8], 1'b1);
      end
      OUT_U16BE: begin
        push_word(cp[15:8], 1'b0);
        push_word(cp[7:0], 1'b1);
      end
      // unused pages fall back to raw
      default: push_word(cp[7:0], 1'b1);
    endcase
  endtask

  // Advance the decoder by one input byte
  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] dlt;
    logic [15:0] cp;
    dlt = {8'h00, b} - U8_CONT;
    if (owed != 0) begin
      if (in_pg == IN_U16LE) begin
        cp = acc_point | {b, 8'h00};
        acc_point = '0;
        owed = '0;
        encode_point(cp);
      end else if (owed == 2'd2) begin
        // middle byte of a three-byte sequence, unchecked and wrapping
        acc_point = acc_point + (dlt << 6);
        owed = 2'd1;
      end else begin
        cp = acc_point + dlt;
        acc_point = '0;
        owed = '0;
        encode_point(cp);
      end
    end else begin
      case (in_pg)
        IN_CP1251: encode_point(point_of_cp1251(b));
        IN_UTF8: begin
          if (b >= U8_LEAD2_LO && b <= U8_LEAD2_HI) begin
            acc_point = {5'b0, b[4:0], 6'b0};
            owed = 2'd1;
          end else if (b >= U8_LEAD3_LO && b <= U8_LEAD3_HI) begin
            acc_point = {b[3:0], 12'b0};
            owed = 2'd2;
          end else begin
            // stray continuation and long lead bytes pass as one character
            encode_point({8'h00, b});
          end
        end
        IN_U16LE: begin
          acc_point = {8'h00, b};
          owed = 2'd1;
        end
        default: encode_point({8'h00, b});
      endcase
    end
  endtask

  // Track registers, check output words, predict from input words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pg = IN_RAW;
      out_pg = OUT_RAW;
      acc_point = '0;
      owed = '0;
      due_q.delete();
      err_cnt_o <= errs;
      words_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IN_PAGE) begin
          // drop any partly decoded character
          in_pg = cfg_data_i[1:0];
          acc_point = '0;
          owed = '0;
        end else if (cfg_idx_i == REG_OUT_PAGE) begin
          out_pg = cfg_data_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= PRINT_CAP)
            $display("%0t: unexpected word, expected none, actual out_byte %02h char_done %0b",
                     $time, out_byte_i, char_done_i);
        end else begin
          want = due_q.pop_front();
          if (out_byte_i !== want.data) begin
            errs++;
            if (errs <= PRINT_CAP)
              $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                       $time, want.data, out_byte_i);
          end
          if (char_done_i !== want.last) begin
            errs++;
            if (errs <= PRINT_CAP)
              $display("%0t: char_done mismatch, expected %0b, actual %0b",
                       $time, want.last, char_done_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        decode_byte(in_byte_i);
      err_cnt_o <= errs;
      words_due_o <= due_q.size();
    end
  end

endmodule

@@ sim/codepage_text_transcoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code page transcoder testbench
// Drives directed and random text bytes through every input and output page,
// with random idle bursts on both channels and one long output hold-off.
// The scoreboard beside the block predicts and checks every output word.
// ----------------------------------------------------------------------------
module codepage_text_transcoder_tb;
  import ctt_pkg::*;

  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned PHASE_WORDS   = 42;
  localparam int unsigned HOLD_PHASE    = 6;
  localparam int unsigned SETTLE_CYC    = 10;
  localparam int unsigned LONG_HOLD_CYC = 80;
  localparam int unsigned TIMEOUT_CYC   = 300000;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  char_done;
  int unsigned           err_cnt;
  int unsigned           words_due;

  logic [1:0]  cur_in_page    = IN_RAW;
  bit          no_idle        = 1'b0;
  bit          long_hold_on   = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned long_cnt       = 0;
  int unsigned stall_left     = 0;

  codepage_text_transcoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .char_done_o (char_done)
  );

  codepage_text_transcoder_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_byte_i  (out_byte),
    .char_done_i (char_done),
    .err_cnt_o   (err_cnt),
    .words_due_o (words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (long_hold_on && !long_hold_done) begin
      out_stall <= 1'b1;
      long_cnt = long_cnt + 1;
      if (long_cnt >= LONG_HOLD_CYC)
        long_hold_done = 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!no_idle && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
    end
    if (!long_hold_on) begin
      long_cnt = 0;
      long_hold_done = 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pages(input logic [1:0] ip, input logic [2:0] op);
    write_reg(REG_IN_PAGE, {1'b0, ip});
    write_reg(REG_OUT_PAGE, op);
    cur_in_page = ip;
  endtask

  // Offer one byte, maybe after an idle burst, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Random text for the current input page; UTF-8 gets mostly whole sequences
  task automatic send_random(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      if (cur_in_page == IN_UTF8) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          send_byte(8'($urandom_range(0, 127)));
          sent += 1;
        end else if (pick < 6) begin
          send_byte(8'($urandom_range(192, 223)));
          send_byte(8'($urandom_range(128, 191)));
          sent += 2;
        end else if (pick < 8) begin
          send_byte(8'($urandom_range(224, 239)));
          send_byte(8'($urandom_range(128, 191)));
          send_byte(8'($urandom_range(128, 191)));
          sent += 3;
        end else if (pick == 8) begin
          send_byte(8'($urandom_range(0, 255)));
          sent += 1;
        end else begin
          // lead byte followed by anything at all
          send_byte(8'($urandom_range(192, 239)));
          send_byte(8'($urandom_range(0, 255)));
          sent += 2;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pages: raw to raw, byte extremes
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    // CP1251 to UTF-8: Cyrillic block ends, Ukrainian letters, ASCII, high latin
    set_pages(IN_CP1251, OUT_UTF8);
    send_byte(8'hC0);
    send_byte(8'hFF);
    send_byte(CP_I_UP);
    send_byte(CP_YI_UP);
    send_byte(CP_I_LO);
    send_byte(CP_YI_LO);
    send_byte(8'h41);
    send_byte(8'h80);
    settle();

    // UTF-8 to CP1251: two and three byte sequences, unmapped point, stray
    // continuation, long lead, and a continuation below 128 that wraps
    set_pages(IN_UTF8, OUT_CP1251);
    send_byte(8'hD0);
    send_byte(8'h90);
    send_byte(8'hD1);
    send_byte(8'h97);
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    send_byte(8'h85);
    send_byte(8'hF5);
    send_byte(8'hC3);
    send_byte(8'h05);
    settle();

    // UTF-8 to UTF-8 at the top of the range, then leave a character open
    set_pages(IN_UTF8, OUT_UTF8);
    send_byte(8'hEF);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'hE2);
    settle();

    // Rewrite in_page with its unused bit set: open character is dropped
    write_reg(REG_IN_PAGE, {1'b1, IN_UTF8});
    write_reg(REG_SPARE_A, 3'd7);
    write_reg(REG_SPARE_B, 3'd5);
    send_byte(8'h41);
    settle();

    // UTF-16LE to UTF-16BE
    set_pages(IN_U16LE, OUT_U16BE);
    send_byte(8'h34);
    send_byte(8'h12);
    settle();

    // Random phases over every input and output page, quiet at the end
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph >= RAND_PHASES - 2);
      if (ph % 3 == 0) begin
        write_reg(REG_SPARE_A, 3'($urandom_range(0, 7)));
        write_reg(REG_SPARE_B, 3'($urandom_range(0, 7)));
      end
      set_pages(2'(ph % 4), 3'((ph * 3) % 8));
      if (ph == HOLD_PHASE)
        long_hold_on = 1'b1;
      send_random(PHASE_WORDS);
      settle();
      if (ph == HOLD_PHASE) begin
        wait (long_hold_done);
        long_hold_on = 1'b0;
      end
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYC * 10);
    $display("TB_ERROR");
    $finish;
  end

endmodule
